// ----- rtl/qdd_pkg.sv -----
package qdd_pkg;

    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    localparam int DEBOUNCE_BITS = 20;
    localparam int DETENT_BITS   = 7;
    localparam int COUNT_BITS    = 8;

    localparam logic [DEBOUNCE_BITS-1:0] DEBOUNCE_RESET = 20'd10000;
    localparam logic [DETENT_BITS-1:0]   DETENT_RESET   = 7'd4;

    localparam logic [15:0] STEP_CW_MAP  = 16'h2814;
    localparam logic [15:0] STEP_CCW_MAP = 16'h4182;

    localparam logic REG_DEBOUNCE = 1'b0;
    localparam logic REG_DETENT   = 1'b1;

    localparam logic KIND_ROTATION = 1'b0;
    localparam logic KIND_BUTTON   = 1'b1;

    typedef struct packed {
        logic rot_valid;
        logic rot_ccw;
        logic btn_valid;
        logic btn_pressed;
    } qdd_entry_t;

    typedef struct packed {
        logic event_kind;
        logic turn_ccw;
        logic pressed;
        logic final_event;
    } qdd_word_t;

endpackage

// ----- rtl/qdd_fifo.sv -----
module qdd_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  qdd_pkg::qdd_entry_t push_entry,
    input  logic               pop,
    output qdd_pkg::qdd_entry_t head,
    output logic               empty,
    output logic               full
);
    import qdd_pkg::*;

    qdd_entry_t                mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_next;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_next;
    logic [QUEUE_CNT_BITS-1:0] count_reg;
    logic [QUEUE_CNT_BITS-1:0] count_next;
    logic                      do_push;
    logic                      do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ----- rtl/qdd_front.sv -----
module qdd_front #(
    parameter int TIME_BITS = 48
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                accept,
    input  logic                                line_a,
    input  logic                                line_b,
    input  logic                                button_level,
    input  logic [TIME_BITS-1:0]                now_us,
    input  logic [qdd_pkg::DEBOUNCE_BITS-1:0]   debounce_time,
    input  logic [qdd_pkg::DETENT_BITS-1:0]     detent_steps,
    output logic                                push,
    output qdd_pkg::qdd_entry_t                 push_entry
);
    import qdd_pkg::*;

    logic                         prev_a_reg;
    logic                         prev_b_reg;
    logic                         prev_button_reg;
    logic signed [COUNT_BITS-1:0] step_count_reg;
    logic signed [COUNT_BITS-1:0] step_count_next;
    logic [TIME_BITS-1:0]         last_change_reg;

    logic [3:0]                   table_idx;
    logic                         step_cw;
    logic                         step_ccw;
    logic signed [COUNT_BITS-1:0] count_sum;
    logic [COUNT_BITS-1:0]        count_mag;
    logic                         detent_hit;
    logic                         btn_change;
    logic [TIME_BITS-1:0]         elapsed;
    logic                         btn_event;

    always_comb
    begin
        table_idx = {prev_b_reg, prev_a_reg, line_b, line_a};
        step_cw   = STEP_CW_MAP[table_idx];
        step_ccw  = STEP_CCW_MAP[table_idx];
        count_sum = step_count_reg;
        if (step_cw)
        begin
            count_sum = step_count_reg + COUNT_BITS'(1);
        end
        else if (step_ccw)
        begin
            count_sum = step_count_reg - COUNT_BITS'(1);
        end
        count_mag  = count_sum[COUNT_BITS-1] ? COUNT_BITS'(-count_sum) : COUNT_BITS'(count_sum);
        detent_hit = (step_cw || step_ccw)
                     && (count_mag >= COUNT_BITS'(detent_steps));
        step_count_next = detent_hit ? '0 : count_sum;

        btn_change = (button_level != prev_button_reg);
        elapsed    = now_us - last_change_reg;
        btn_event  = btn_change && (elapsed > TIME_BITS'(debounce_time));

        push                   = accept && (detent_hit || btn_event);
        push_entry.rot_valid   = detent_hit;
        push_entry.rot_ccw     = count_sum[COUNT_BITS-1];
        push_entry.btn_valid   = btn_event;
        push_entry.btn_pressed = !button_level;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_a_reg      <= 1'b1;
            prev_b_reg      <= 1'b1;
            prev_button_reg <= 1'b1;
            step_count_reg  <= '0;
            last_change_reg <= '0;
        end
        else if (accept)
        begin
            prev_a_reg      <= line_a;
            prev_b_reg      <= line_b;
            prev_button_reg <= button_level;
            step_count_reg  <= step_count_next;
            if (btn_change)
            begin
                last_change_reg <= now_us;
            end
        end
    end

endmodule

// ----- rtl/qdd_back.sv -----
module qdd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  qdd_pkg::qdd_entry_t head,
    input  logic                empty,
    output logic                pop,
    input  logic                word_ready,
    output logic                word_valid,
    output qdd_pkg::qdd_word_t  word
);
    import qdd_pkg::*;

    logic      out_valid_reg;
    logic      out_valid_next;
    qdd_word_t out_word_reg;
    qdd_word_t out_word_next;
    logic      pend_btn_reg;
    logic      pend_btn_next;
    logic      pend_pressed_reg;
    logic      pend_pressed_next;
    logic      load;

    assign word_valid = out_valid_reg;
    assign word       = out_word_reg;

    always_comb
    begin
        load              = !out_valid_reg || word_ready;
        pop               = 1'b0;
        out_valid_next    = out_valid_reg && !word_ready;
        out_word_next     = out_word_reg;
        pend_btn_next     = pend_btn_reg;
        pend_pressed_next = pend_pressed_reg;
        if (load)
        begin
            if (pend_btn_reg)
            begin
                out_valid_next            = 1'b1;
                out_word_next.event_kind  = KIND_BUTTON;
                out_word_next.turn_ccw    = 1'b0;
                out_word_next.pressed     = pend_pressed_reg;
                out_word_next.final_event = 1'b1;
                pend_btn_next             = 1'b0;
            end
            else if (!empty)
            begin
                pop            = 1'b1;
                out_valid_next = 1'b1;
                if (head.rot_valid)
                begin
                    out_word_next.event_kind  = KIND_ROTATION;
                    out_word_next.turn_ccw    = head.rot_ccw;
                    out_word_next.pressed     = 1'b0;
                    out_word_next.final_event = !head.btn_valid;
                    pend_btn_next             = head.btn_valid;
                    pend_pressed_next         = head.btn_pressed;
                end
                else
                begin
                    out_word_next.event_kind  = KIND_BUTTON;
                    out_word_next.turn_ccw    = 1'b0;
                    out_word_next.pressed     = head.btn_pressed;
                    out_word_next.final_event = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_btn_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pend_btn_reg  <= pend_btn_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg     <= out_word_next;
        pend_pressed_reg <= pend_pressed_next;
    end

endmodule

// ----- rtl/quadrature_detent_decoder.sv -----
// Quadrature encoder and push-button decoder.
// Sample channel: one word per sampling tick carrying line_a, line_b,
// button_level (low = pressed) and the microsecond timestamp now_us.
// A word is taken on any cycle with sample_valid and sample_ready high.
// Event channel: rotation events (event_kind 0, turn_ccw) and button
// events (event_kind 1, pressed); final_event marks the last event of a
// sample. A sample yields zero, one or two events, rotation first.
// Throughput: one sample per cycle while sample_ready is high; the event
// port moves one word per cycle while event_ready is high.
// Path: an event's sample is queued in the FIFO at the accepting edge,
// then the event is loaded into the output register once that register can load.
// When the event receiver stalls, the queue fills and sample_ready drops
// once four samples with events are waiting; event-free samples never
// enter the queue.
// Reset: lines A, B and the button read as high, step count and last
// button time clear, debounce_time = 10000 us and detent_steps = 4.
// APB registers: 0x0 debounce_time (20 bits), 0x4 detent_steps (7 bits).
module quadrature_detent_decoder #(
    parameter int TIME_BITS = 48
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 sample_valid,
    output logic                 sample_ready,
    input  logic                 line_a,
    input  logic                 line_b,
    input  logic                 button_level,
    input  logic [TIME_BITS-1:0] now_us,
    output logic                 event_valid,
    input  logic                 event_ready,
    output logic                 event_kind,
    output logic                 turn_ccw,
    output logic                 pressed,
    output logic                 final_event
);
    import qdd_pkg::*;

    logic [DEBOUNCE_BITS-1:0] debounce_reg;
    logic [DETENT_BITS-1:0]   detent_reg;
    logic                     cfg_write;
    logic                     accept;
    logic                     push;
    qdd_entry_t               push_entry;
    logic                     pop;
    qdd_entry_t               head;
    logic                     empty;
    logic                     full;
    qdd_word_t                word;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[2])
            REG_DEBOUNCE: prdata = 32'(debounce_reg);
            REG_DETENT:   prdata = 32'(detent_reg);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RESET;
            detent_reg   <= DETENT_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_DEBOUNCE)
            begin
                debounce_reg <= pwdata[DEBOUNCE_BITS-1:0];
            end
            else
            begin
                detent_reg <= pwdata[DETENT_BITS-1:0];
            end
        end
    end

    assign sample_ready = !full;
    assign accept       = sample_valid && sample_ready;

    qdd_front #(
        .TIME_BITS (TIME_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .line_a        (line_a),
        .line_b        (line_b),
        .button_level  (button_level),
        .now_us        (now_us),
        .debounce_time (debounce_reg),
        .detent_steps  (detent_reg),
        .push          (push),
        .push_entry    (push_entry)
    );

    qdd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (empty),
        .full       (full)
    );

    qdd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .empty      (empty),
        .pop        (pop),
        .word_ready (event_ready),
        .word_valid (event_valid),
        .word       (word)
    );

    assign event_kind  = word.event_kind;
    assign turn_ccw    = word.turn_ccw;
    assign pressed     = word.pressed;
    assign final_event = word.final_event;

endmodule
